>>> design/ps2sc_pkg.sv
// Constants and character table for the scan code set 1 to ASCII decoder.
package ps2sc_pkg;

	// Byte and key codes (low seven bits of the scan code)
	localparam logic [7:0] PrefixByte = 8'hE0;
	localparam logic [6:0] RomSize    = 7'h3B;
	localparam logic [6:0] KeyLShift  = 7'h2A;
	localparam logic [6:0] KeyRShift  = 7'h36;
	localparam logic [6:0] KeyAlt     = 7'h38;
	localparam logic [6:0] KeyCtrl    = 7'h1D;
	localparam logic [6:0] KeyCaps    = 7'h3A;

	// Result kinds carried in tuser
	localparam logic KindChar    = 1'b0;
	localparam logic KindUnknown = 1'b1;

	// Character pair for a key: {unshifted, shifted}, zero where the key prints nothing
	function automatic logic [13:0] char_pair(input logic [5:0] idx);
		logic [13:0] pair;
		case (idx)
			6'h01: pair = {7'h1B, 7'h1B};
			6'h02: pair = {7'h31, 7'h21};
			6'h03: pair = {7'h32, 7'h40};
			6'h04: pair = {7'h33, 7'h23};
			6'h05: pair = {7'h34, 7'h24};
			6'h06: pair = {7'h35, 7'h25};
			6'h07: pair = {7'h36, 7'h5E};
			6'h08: pair = {7'h37, 7'h26};
			6'h09: pair = {7'h38, 7'h2A};
			6'h0A: pair = {7'h39, 7'h28};
			6'h0B: pair = {7'h30, 7'h29};
			6'h0C: pair = {7'h2D, 7'h5F};
			6'h0D: pair = {7'h3D, 7'h2B};
			6'h0E: pair = {7'h08, 7'h08};
			6'h0F: pair = {7'h09, 7'h09};
			6'h10: pair = {7'h71, 7'h51};
			6'h11: pair = {7'h77, 7'h57};
			6'h12: pair = {7'h65, 7'h45};
			6'h13: pair = {7'h72, 7'h52};
			6'h14: pair = {7'h74, 7'h54};
			6'h15: pair = {7'h79, 7'h59};
			6'h16: pair = {7'h75, 7'h55};
			6'h17: pair = {7'h69, 7'h49};
			6'h18: pair = {7'h6F, 7'h4F};
			6'h19: pair = {7'h70, 7'h50};
			6'h1A: pair = {7'h5B, 7'h7B};
			6'h1B: pair = {7'h5D, 7'h7D};
			6'h1C: pair = {7'h0D, 7'h0D};
			6'h1E: pair = {7'h61, 7'h41};
			6'h1F: pair = {7'h73, 7'h53};
			6'h20: pair = {7'h64, 7'h44};
			6'h21: pair = {7'h66, 7'h46};
			6'h22: pair = {7'h67, 7'h47};
			6'h23: pair = {7'h68, 7'h48};
			6'h24: pair = {7'h6A, 7'h4A};
			6'h25: pair = {7'h6B, 7'h4B};
			6'h26: pair = {7'h6C, 7'h4C};
			6'h27: pair = {7'h3B, 7'h3A};
			6'h28: pair = {7'h27, 7'h22};
			6'h29: pair = {7'h60, 7'h7E};
			6'h2B: pair = {7'h5C, 7'h7C};
			6'h2C: pair = {7'h7A, 7'h5A};
			6'h2D: pair = {7'h78, 7'h58};
			6'h2E: pair = {7'h63, 7'h43};
			6'h2F: pair = {7'h76, 7'h56};
			6'h30: pair = {7'h62, 7'h42};
			6'h31: pair = {7'h6E, 7'h4E};
			6'h32: pair = {7'h6D, 7'h4D};
			6'h33: pair = {7'h2C, 7'h3C};
			6'h34: pair = {7'h2E, 7'h3E};
			6'h35: pair = {7'h2F, 7'h3F};
			6'h37: pair = {7'h2A, 7'h2A};
			6'h39: pair = {7'h20, 7'h20};
			default: pair = 14'h0;
		endcase
		return pair;
	endfunction

endpackage

>>> design/ps2_scancode_to_ascii.sv
// Scan code set 1 to ASCII decoder: input register, decode, result register.
// Table lookup and modifier update sit in one stage feeding the result register.
// Throughput: one byte per cycle while the master side is not stalled.
// Bytes that give no result (prefix, releases, modifier presses) still take one slot.
// Reset clears the prefix flag, all modifiers, caps lock and both valid flags.
module ps2_scancode_to_ascii import ps2sc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] scan_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] char_code, [7] ctrl_held, [8] alt_held, rest zero
	output logic        m_tuser    // [0] kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       prefix_q, ctrl_q, shift_q, alt_q, caps_q;
	logic       out_valid_q;
	logic       kind_q;
	logic [6:0] char_q;
	logic       ctrl_out_q, alt_out_q;

	logic        advance;
	logic        ext, rel;
	logic [6:0]  low;
	logic        sym, col;
	logic [13:0] pair;
	logic [6:0]  ch;
	logic        prefix_d, ctrl_d, shift_d, alt_d, caps_d;
	logic        emit, emit_kind;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Decode
	assign ext  = prefix_q;
	assign rel  = byte_s1[7];
	assign low  = byte_s1[6:0];
	assign sym  = (low < 7'h10) || (low inside {7'h1A, 7'h1B, 7'h1C, 7'h27, 7'h28, 7'h2B,
		7'h33, 7'h34, 7'h35});
	assign col  = sym ? shift_q : (shift_q ^ caps_q);
	assign pair = char_pair(low[5:0]);
	assign ch   = col ? pair[6:0] : pair[13:7];

	always_comb begin
		prefix_d  = 1'b0;
		ctrl_d    = ctrl_q;
		shift_d   = shift_q;
		alt_d     = alt_q;
		caps_d    = caps_q;
		emit      = 1'b0;
		emit_kind = KindChar;
		if (byte_s1 == PrefixByte) begin
			prefix_d = 1'b1;
		end else if (rel) begin
			// Key release: only modifiers matter
			if (low == KeyCtrl) begin
				ctrl_d = 1'b0;
			end else if (!ext && (low inside {KeyLShift, KeyRShift})) begin
				shift_d = 1'b0;
			end else if (low == KeyAlt) begin
				alt_d = 1'b0;
			end
		end else if (ext) begin
			// Extended press: right ctrl and right alt only
			if (low == KeyCtrl) begin
				ctrl_d = 1'b1;
			end else if (low == KeyAlt) begin
				alt_d = 1'b1;
			end
		end else if (low < RomSize) begin
			if (ch != 7'h0) begin
				emit = 1'b1;
			end else if (low inside {KeyLShift, KeyRShift}) begin
				shift_d = 1'b1;
			end else if (low == KeyCtrl) begin
				ctrl_d = 1'b1;
			end else if (low == KeyAlt) begin
				alt_d = 1'b1;
			end else if (low == KeyCaps) begin
				caps_d = !caps_q;
			end else begin
				emit      = 1'b1;
				emit_kind = KindUnknown;
			end
		end
	end

	// Key state, updated as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			ctrl_q   <= 1'b0;
			shift_q  <= 1'b0;
			alt_q    <= 1'b0;
			caps_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			prefix_q <= prefix_d;
			ctrl_q   <= ctrl_d;
			shift_q  <= shift_d;
			alt_q    <= alt_d;
			caps_q   <= caps_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			kind_q     <= emit_kind;
			char_q     <= (emit_kind == KindUnknown) ? 7'h0 : ch;
			ctrl_out_q <= ctrl_q;
			alt_out_q  <= alt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'h0, alt_out_q, ctrl_out_q, char_q};
	assign m_tuser  = kind_q;

endmodule

>>> tb/ps2_scancode_to_ascii_tb.sv
// Self-checking testbench for the scan code set 1 to ASCII decoder, with its own decode model.
`timescale 1ns / 100ps
module ps2_scancode_to_ascii_tb;
	import ps2sc_pkg::*;

	localparam int ClkPeriod   = 12;
	localparam int ResetCycles = 8;
	localparam int CycleLimit  = 1000000;
	localparam int RandomKeys  = 1820;
	localparam int DrainCycles = 8;
	localparam int MaxReported = 10;

	// Full key codes, extended keys carry the prefix byte in the upper half
	localparam logic [15:0] CodeLShift = {9'h0, KeyLShift};
	localparam logic [15:0] CodeRShift = {9'h0, KeyRShift};
	localparam logic [15:0] CodeLCtrl  = {9'h0, KeyCtrl};
	localparam logic [15:0] CodeRCtrl  = {PrefixByte, 1'b0, KeyCtrl};
	localparam logic [15:0] CodeLAlt   = {9'h0, KeyAlt};
	localparam logic [15:0] CodeRAlt   = {PrefixByte, 1'b0, KeyAlt};
	localparam logic [15:0] CodeCaps   = {9'h0, KeyCaps};
	localparam logic [15:0] CodeRomEnd = {9'h0, RomSize};
	localparam logic [7:0]  ReleaseBit = 8'h80;

	typedef struct packed {
		logic       kind;
		logic [6:0] char_code;
		logic       ctrl_held;
		logic       alt_held;
	} key_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] scan_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [6:0] char_code, [7] ctrl_held, [8] alt_held, rest zero
	logic        m_tuser;    // [0] kind

	// Keyboard state as the decoder should hold it
	logic pfx_armed = 1'b0;
	logic ctrl_on   = 1'b0;
	logic shift_on  = 1'b0;
	logic alt_on    = 1'b0;
	logic caps_lock = 1'b0;

	key_result_t expected_keys[$];

	// When set, neither side inserts idle cycles
	logic steady = 1'b0;

	int cycle_count    = 0;
	int error_count    = 0;
	int bytes_sent     = 0;
	int keys_effective = 0;
	int results_seen   = 0;
	int chars_seen     = 0;
	int unknown_seen   = 0;

	ps2_scancode_to_ascii i_dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tuser
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Character pair for a key: {unshifted, shifted}, zero where nothing prints
	function automatic logic [15:0] key_chars(input logic [5:0] idx);
		case (idx)
			6'h01: return {8'h1B, 8'h1B};
			6'h02: return {"1", "!"};
			6'h03: return {"2", "@"};
			6'h04: return {"3", "#"};
			6'h05: return {"4", "$"};
			6'h06: return {"5", "%"};
			6'h07: return {"6", "^"};
			6'h08: return {"7", "&"};
			6'h09: return {"8", "*"};
			6'h0A: return {"9", "("};
			6'h0B: return {"0", ")"};
			6'h0C: return {"-", "_"};
			6'h0D: return {"=", "+"};
			6'h0E: return {8'h08, 8'h08};
			6'h0F: return {8'h09, 8'h09};
			6'h10: return {"q", "Q"};
			6'h11: return {"w", "W"};
			6'h12: return {"e", "E"};
			6'h13: return {"r", "R"};
			6'h14: return {"t", "T"};
			6'h15: return {"y", "Y"};
			6'h16: return {"u", "U"};
			6'h17: return {"i", "I"};
			6'h18: return {"o", "O"};
			6'h19: return {"p", "P"};
			6'h1A: return {"[", "{"};
			6'h1B: return {"]", "}"};
			6'h1C: return {8'h0D, 8'h0D};
			6'h1E: return {"a", "A"};
			6'h1F: return {"s", "S"};
			6'h20: return {"d", "D"};
			6'h21: return {"f", "F"};
			6'h22: return {"g", "G"};
			6'h23: return {"h", "H"};
			6'h24: return {"j", "J"};
			6'h25: return {"k", "K"};
			6'h26: return {"l", "L"};
			6'h27: return {";", ":"};
			6'h28: return {"'", "\""};
			6'h29: return {8'h60, "~"};
			6'h2B: return {"\\", "|"};
			6'h2C: return {"z", "Z"};
			6'h2D: return {"x", "X"};
			6'h2E: return {"c", "C"};
			6'h2F: return {"v", "V"};
			6'h30: return {"b", "B"};
			6'h31: return {"n", "N"};
			6'h32: return {"m", "M"};
			6'h33: return {",", "<"};
			6'h34: return {".", ">"};
			6'h35: return {"/", "?"};
			6'h37: return {"*", "*"};
			6'h39: return {" ", " "};
			default: return 16'h0;
		endcase
	endfunction

	// Symbol keys follow shift alone; everything else, backtick included, sees caps lock too
	function automatic logic is_symbol(input logic [15:0] code);
		case (code)
			16'h001A, 16'h001B, 16'h001C, 16'h0027, 16'h0028,
			16'h002B, 16'h0033, 16'h0034, 16'h0035: return 1'b1;
			default: return code < 16'h0010;
		endcase
	endfunction

	// Decode one accepted byte: update the keyboard state, give the result if there is one
	function automatic void decode_scan_byte(input logic [7:0] scan, output logic has_result,
			output key_result_t res);
		logic [15:0] code;
		logic        released;
		logic        col;
		logic [15:0] pair;
		logic [6:0]  ch;
		has_result = 1'b0;
		res = '0;
		if (scan == PrefixByte) begin
			pfx_armed = 1'b1;
			return;
		end
		code = pfx_armed ? {PrefixByte, scan} : {8'h00, scan};
		pfx_armed = 1'b0;
		released = code[7];
		code[7] = 1'b0;

		// Releases only ever clear a modifier
		if (released) begin
			if (code == CodeLCtrl || code == CodeRCtrl)
				ctrl_on = 1'b0;
			else if (code == CodeLShift || code == CodeRShift)
				shift_on = 1'b0;
			else if (code == CodeLAlt || code == CodeRAlt)
				alt_on = 1'b0;
			return;
		end

		if (code < CodeRomEnd || code == CodeRAlt || code == CodeRCtrl) begin
			col = is_symbol(code) ? shift_on : (shift_on ^ caps_lock);
			pair = (code < CodeRomEnd) ? key_chars(code[5:0]) : 16'h0;
			ch = col ? pair[6:0] : pair[14:8];
			if (ch != 7'h0) begin
				has_result = 1'b1;
				res = '{KindChar, ch, ctrl_on, alt_on};
			end else if (code == CodeLShift || code == CodeRShift) begin
				shift_on = 1'b1;
			end else if (code == CodeLCtrl || code == CodeRCtrl) begin
				ctrl_on = 1'b1;
			end else if (code == CodeLAlt || code == CodeRAlt) begin
				alt_on = 1'b1;
			end else if (code == CodeCaps) begin
				caps_lock = ~caps_lock;
			end else begin
				has_result = 1'b1;
				res = '{KindUnknown, 7'h0, ctrl_on, alt_on};
			end
		end
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Send one byte; the expected result is worked out at the accepting edge
	task automatic send_byte(input logic [7:0] scan);
		int          gap;
		logic        has_result;
		key_result_t res;
		logic [4:0]  state_before;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= scan;
		do @(posedge clk); while (!s_tready);
		state_before = {pfx_armed, ctrl_on, shift_on, alt_on, caps_lock};
		decode_scan_byte(scan, has_result, res);
		if (has_result)
			expected_keys.push_back(res);
		bytes_sent++;
		if (has_result || state_before != {pfx_armed, ctrl_on, shift_on, alt_on, caps_lock})
			keys_effective++;
	endtask

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= MaxReported)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endfunction

	// Sink side: random back-pressure
	initial begin
		int stall;
		m_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		key_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser == KindUnknown)
				unknown_seen++;
			else
				chars_seen++;
			if (expected_keys.size() == 0) begin
				report_error($sformatf("unexpected result kind=%0b char=%02h tdata=%04h",
					m_tuser, m_tdata[6:0], m_tdata));
			end else begin
				want = expected_keys.pop_front();
				if (m_tuser !== want.kind || m_tdata[6:0] !== want.char_code ||
						m_tdata[7] !== want.ctrl_held || m_tdata[8] !== want.alt_held ||
						m_tdata[15:9] !== 7'h0)
					report_error({
						$sformatf("result %0d: expected kind=%0b char=%02h ctrl=%0b alt=%0b, ",
							results_seen, want.kind, want.char_code, want.ctrl_held,
							want.alt_held),
						$sformatf("got kind=%0b char=%02h ctrl=%0b alt=%0b pad=%02h",
							m_tuser, m_tdata[6:0], m_tdata[7], m_tdata[8], m_tdata[15:9])});
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still outstanding",
				cycle_count, expected_keys.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Code zero, an out-of-table code and a release of the highest code
	task automatic test_code_extremes();
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'hFF);
	endtask

	// Both shifts, caps lock on backtick and a symbol key, left ctrl
	task automatic test_modifiers_and_caps();
		send_byte({1'b0, KeyLShift});
		send_byte(8'h1E);
		send_byte({1'b1, KeyLShift});
		send_byte({1'b0, KeyRShift});
		send_byte(8'h02);
		send_byte({1'b1, KeyRShift});
		send_byte({1'b0, KeyCaps});
		send_byte(8'h29);
		send_byte(8'h0C);
		send_byte({1'b1, KeyCaps});
		send_byte({1'b0, KeyCaps});
		send_byte({1'b0, KeyCtrl});
		send_byte(8'h10);
		send_byte({1'b1, KeyCtrl});
	endtask

	// Right alt and ctrl, a doubled prefix and an ignored extended key
	task automatic test_extended_prefix();
		send_byte(PrefixByte);
		send_byte({1'b0, KeyAlt});
		send_byte(PrefixByte);
		send_byte(PrefixByte);
		send_byte(8'h1C);
		send_byte(PrefixByte);
		send_byte({1'b0, KeyCtrl});
		send_byte(8'h39);
		send_byte(PrefixByte);
		send_byte({1'b1, KeyCtrl});
		send_byte(PrefixByte);
		send_byte({1'b1, KeyAlt});
	endtask

	function automatic logic [7:0] modifier_byte();
		case ($urandom_range(0, 4))
			0: return {1'b0, KeyLShift};
			1: return {1'b0, KeyRShift};
			2: return {1'b0, KeyCtrl};
			3: return {1'b0, KeyAlt};
			default: return {1'b0, KeyCaps};
		endcase
	endfunction

	// Typing: key press and release pairs, modifier traffic, extended keys and line noise
	task automatic test_random_typing(input int target);
		int         goal;
		int         pick;
		logic [7:0] key;
		goal = bytes_sent + target;
		while (bytes_sent < goal) begin
			if ($urandom_range(0, 149) == 0)
				steady = ~steady;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				key = 8'($urandom_range(1, 8'h39));
				send_byte(key);
				send_byte(key | ReleaseBit);
			end else if (pick < 60) begin
				send_byte(modifier_byte());
			end else if (pick < 70) begin
				send_byte(modifier_byte() | ReleaseBit);
			end else if (pick < 82) begin
				send_byte(PrefixByte);
				case ($urandom_range(0, 4))
					0: send_byte({1'b0, KeyCtrl});
					1: send_byte({1'b0, KeyAlt});
					2: send_byte({1'b1, KeyCtrl});
					3: send_byte({1'b1, KeyAlt});
					default: send_byte(8'($urandom_range(0, 255)));
				endcase
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_code_extremes();
		test_modifiers_and_caps();
		test_extended_prefix();
		test_random_typing(RandomKeys);
		s_tvalid <= 1'b0;

		// Drain, then allow for the pipeline
		while (expected_keys.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d scan bytes (%0d changed state or produced output) in %0d cycles",
			bytes_sent, keys_effective, cycle_count);
		$display("checked %0d results: %0d characters, %0d unknown keys; %0d errors",
			results_seen, chars_seen, unknown_seen, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
